[rtl/core/ptm_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_pkg
// Shared types, constants and elaboration-time log table for the note tracker.
// ============================================================================
package ptm_pkg;

    localparam int HOLD_COUNT_BITS = 24;
    localparam int LOG_TAB_N       = 64;
    localparam int LOG_TAB_IW      = $clog2(LOG_TAB_N);
    localparam int LOG_TAB_AW      = $clog2(LOG_TAB_N + 1);
    localparam int LOG_PROD_W      = 31 + LOG_TAB_IW;

    localparam int HZ_W    = 23;
    localparam int CONF_W  = 16;
    localparam int LEN_W   = 16;
    localparam int CHAN_W  = 4;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int BEND_W  = 14;
    localparam int KIND_W  = 2;
    localparam int HOLD_W  = 24;
    localparam int LOG_W   = 22;
    localparam int MIDI_W  = 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_EN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_FLOOR = 3'd4;

    localparam logic [HOLD_W-1:0] MIN_HOLD_RST   = 24'd2205;
    localparam logic [CONF_W-1:0] CONF_FLOOR_RST = 16'd19660;

    localparam logic [KIND_W-1:0] EV_NOTE_OFF = 2'd0;
    localparam logic [KIND_W-1:0] EV_NOTE_ON  = 2'd1;
    localparam logic [KIND_W-1:0] EV_BEND     = 2'd2;

    typedef logic [LOG_TAB_N:0][16:0] t_log_tab;

    typedef struct packed {
        logic bypass;
        logic out_en;
        logic [CHAN_W-1:0] channel;
        logic [HOLD_W-1:0] min_hold;
        logic [CONF_W-1:0] conf_floor;
    } t_cfg;

    typedef struct packed {
        logic pitch_ok;
        logic [NOTE_W-1:0] target;
        logic [VEL_W-1:0] velocity;
        logic [BEND_W-1:0] bend;
        logic [LEN_W-1:0] len;
    } t_rec;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0] velocity;
        logic [BEND_W-1:0] bend;
    } t_event;

    // log2 of x in Q2.30 (1 <= x < 2), Q16, by truncated repeated squaring
    function automatic logic [15:0] frac_log2(logic [63:0] x_in);
        logic [63:0] x;
        logic [15:0] v;
        x = x_in;
        v = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            v = {v[14:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                v[0] = 1'b1;
                x = x >> 1;
            end
        end
        return v;
    endfunction

    function automatic t_log_tab build_log_tab();
        t_log_tab tab;
        logic [63:0] x;
        for (int i = 0; i < LOG_TAB_N; i++) begin
            x = (64'(LOG_TAB_N + i) << 30) / 64'(LOG_TAB_N);
            tab[i] = {1'b0, frac_log2(x)};
        end
        tab[LOG_TAB_N] = 17'h10000;
        return tab;
    endfunction

    localparam t_log_tab LOG_TAB = build_log_tab();

    function automatic logic [LOG_W-1:0] log2_q16_c(logic [HZ_W-1:0] h);
        int p;
        logic [63:0] m, f, prod, i, r, lo, hi;
        p = 0;
        for (int k = 0; k < HZ_W; k++) begin
            if (h[k]) p = k;
        end
        m = 64'(h) << (31 - p);
        f = m - 64'h8000_0000;
        prod = f * 64'(LOG_TAB_N);
        i = prod >> 31;
        r = prod - (i << 31);
        lo = 64'(LOG_TAB[i]);
        hi = 64'(LOG_TAB[i + 1]);
        return LOG_W'(64'(p) * 64'd65536 + lo + (((hi - lo) * r) >> 31));
    endfunction

    localparam logic [LOG_W-1:0] LOG_440 = log2_q16_c(23'd450560);

endpackage

[rtl/core/ptm_pitch_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_pitch_if
// Input channel: one audio block's pitch, confidence and length.
// ============================================================================
interface ptm_pitch_if;
    import ptm_pkg::*;

    logic valid;
    logic ready;
    logic [HZ_W-1:0] corrected_hz;
    logic [CONF_W-1:0] confidence;
    logic [LEN_W-1:0] block_samples;

    modport source (output valid, corrected_hz, confidence, block_samples, input ready);
    modport sink (input valid, corrected_hz, confidence, block_samples, output ready);
endinterface

[rtl/core/ptm_event_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_event_if
// Output channel: one MIDI event per transfer.
// ============================================================================
interface ptm_event_if;
    import ptm_pkg::*;

    logic valid;
    logic ready;
    logic [KIND_W-1:0] event_kind;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0] note_velocity;
    logic [BEND_W-1:0] bend_value;
    logic last_event;

    modport source (output valid, event_kind, channel, note_number, note_velocity,
                    bend_value, last_event, input ready);
    modport sink (input valid, event_kind, channel, note_number, note_velocity,
                  bend_value, last_event, output ready);
endinterface

[rtl/core/ptm_queue.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_queue
// Two-entry queue of classified records between front and back.
// ============================================================================
module ptm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ptm_pkg::t_rec i_data,
    output logic          o_full,
    input  logic          i_pop,
    output ptm_pkg::t_rec o_data,
    output logic          o_empty
);
    import ptm_pkg::*;

    t_rec       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

[rtl/core/ptm_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_front
// Accepts blocks, drops suppressed ones and computes note, velocity and bend.
// ============================================================================
module ptm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptm_pkg::t_cfg i_cfg,
    ptm_pitch_if.sink     i_pitch,
    output logic          o_push,
    output ptm_pkg::t_rec o_rec,
    input  logic          i_full
);
    import ptm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LZ   = 3'd1;
    localparam logic [2:0] ST_NORM = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MIDI = 3'd4;
    localparam logic [2:0] ST_TGT  = 3'd5;
    localparam logic [2:0] ST_BEND = 3'd6;
    localparam logic [2:0] ST_PUSH = 3'd7;

    logic [2:0] r_state, n_state;

    logic [HZ_W-1:0]   r_hz;
    logic [CONF_W-1:0] r_conf;
    logic [LEN_W-1:0]  r_len;
    logic              r_ok;
    logic [4:0]        r_p;
    logic [16:0]       r_lo, r_dlt;
    logic [30:0]       r_frac;
    logic [16:0]       r_interp;
    logic signed [MIDI_W-1:0] r_midi;
    logic [VEL_W-1:0]  r_vel;
    logic [NOTE_W-1:0] r_target;
    logic [MIDI_W-1:0] r_mag;
    logic              r_neg;
    logic [BEND_W-1:0] r_bend;

    logic accept, drop, pitch_ok;
    logic [4:0] lz_p;
    logic [31:0] norm_m;
    logic [LOG_PROD_W-1:0] prod;
    logic [LOG_TAB_AW-1:0] tab_i;
    logic [16:0] tab_lo, tab_hi;
    logic [47:0] interp_full;
    logic [LOG_W-1:0] log_v;
    logic signed [LOG_W+1:0] log_d;
    logic signed [MIDI_W-1:0] midi_v;
    logic [23:0] vel_sum;
    logic [7:0] vel_raw;
    logic [VEL_W-1:0] vel_c;
    logic signed [MIDI_W:0] rnd;
    logic [NOTE_W-1:0] tgt_c;
    logic signed [MIDI_W:0] d_v;
    logic [MIDI_W:0] mag_v;
    logic [MIDI_W+12:0] q_full;
    logic [14:0] q_c;
    logic signed [15:0] bend_s;
    logic [BEND_W-1:0] bend_c;

    assign i_pitch.ready = (r_state == ST_IDLE);
    assign accept   = i_pitch.valid && i_pitch.ready;
    assign drop     = i_cfg.bypass || !i_cfg.out_en || (i_pitch.block_samples == '0);
    assign pitch_ok = (i_pitch.corrected_hz != '0) && (i_pitch.confidence > i_cfg.conf_floor);

    always_comb begin
        lz_p = 5'd0;
        for (int k = 0; k < HZ_W; k++) begin
            if (r_hz[k]) lz_p = 5'(k);
        end
    end

    always_comb begin
        norm_m = 32'(r_hz) << (5'd31 - r_p);
        prod   = LOG_PROD_W'(norm_m[30:0]) * LOG_PROD_W'(LOG_TAB_N);
        tab_i  = LOG_TAB_AW'(prod[LOG_PROD_W-1:31]);
        tab_lo = LOG_TAB[tab_i];
        tab_hi = LOG_TAB[tab_i + LOG_TAB_AW'(1)];
    end

    assign interp_full = 48'(r_dlt) * 48'(r_frac);

    always_comb begin
        log_v   = LOG_W'({r_p, 16'd0}) + LOG_W'(r_lo) + LOG_W'(r_interp);
        log_d   = $signed({2'b00, log_v}) - $signed({2'b00, LOG_440});
        midi_v  = MIDI_W'($signed(69 * 65536)) + MIDI_W'(log_d * 12);
        vel_sum = 24'(r_conf) * 24'd100 + 24'(27 * 65536);
        vel_raw = vel_sum[23:16];
        if (vel_raw == 8'd0)        vel_c = 7'd1;
        else if (vel_raw > 8'd127)  vel_c = 7'd127;
        else                        vel_c = vel_raw[6:0];
    end

    always_comb begin
        rnd = $signed({r_midi[MIDI_W-1], r_midi}) + (MIDI_W+1)'(32768);
        if (r_midi[MIDI_W-1])                tgt_c = 7'd0;
        else if (rnd[MIDI_W:16] > 127)       tgt_c = 7'd127;
        else                                 tgt_c = rnd[22:16];
        d_v   = $signed({r_midi[MIDI_W-1], r_midi}) - $signed((MIDI_W+1)'({tgt_c, 16'd0}));
        mag_v = d_v[MIDI_W] ? (MIDI_W+1)'(-d_v) : (MIDI_W+1)'(d_v);
    end

    always_comb begin
        q_full = (MIDI_W+13)'(r_mag) * (MIDI_W+13)'(8191);
        if (q_full[MIDI_W+12:17] > 16384) q_c = 15'd16384;
        else                               q_c = q_full[31:17];
        bend_s = r_neg ? (16'sd8192 - $signed({1'b0, q_c}))
                       : (16'sd8192 + $signed({1'b0, q_c}));
        if (bend_s < 0)              bend_c = '0;
        else if (bend_s > 16'sd16383) bend_c = 14'd16383;
        else                         bend_c = bend_s[13:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept && !drop) n_state = pitch_ok ? ST_LZ : ST_PUSH;
            ST_LZ:   n_state = ST_NORM;
            ST_NORM: n_state = ST_MUL;
            ST_MUL:  n_state = ST_MIDI;
            ST_MIDI: n_state = ST_TGT;
            ST_TGT:  n_state = ST_BEND;
            ST_BEND: n_state = ST_PUSH;
            ST_PUSH: if (!i_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hz   <= i_pitch.corrected_hz;
            r_conf <= i_pitch.confidence;
            r_len  <= i_pitch.block_samples;
            r_ok   <= pitch_ok;
        end
        if (r_state == ST_LZ) r_p <= lz_p;
        if (r_state == ST_NORM) begin
            r_lo   <= tab_lo;
            r_dlt  <= tab_hi - tab_lo;
            r_frac <= prod[30:0];
        end
        if (r_state == ST_MUL) r_interp <= interp_full[47:31];
        if (r_state == ST_MIDI) begin
            r_midi <= midi_v;
            r_vel  <= vel_c;
        end
        if (r_state == ST_TGT) begin
            r_target <= tgt_c;
            r_mag    <= mag_v[MIDI_W-1:0];
            r_neg    <= d_v[MIDI_W];
        end
        if (r_state == ST_BEND) r_bend <= bend_c;
    end

    assign o_push = (r_state == ST_PUSH) && !i_full;
    always_comb begin
        o_rec.pitch_ok = r_ok;
        o_rec.target   = r_target;
        o_rec.velocity = r_vel;
        o_rec.bend     = r_bend;
        o_rec.len      = r_len;
    end
endmodule

[rtl/core/ptm_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_back
// Note state with hold hysteresis; sequences up to three events per record.
// ============================================================================
module ptm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptm_pkg::t_cfg i_cfg,
    input  ptm_pkg::t_rec i_rec,
    input  logic          i_empty,
    output logic          o_pop,
    ptm_event_if.source   o_event
);
    import ptm_pkg::*;

    localparam int CMP_W = (HOLD_COUNT_BITS > HOLD_W) ? HOLD_COUNT_BITS : HOLD_W;
    localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;

    logic                       r_sounding, n_sounding;
    logic [NOTE_W-1:0]          r_note, n_note;
    logic [HOLD_COUNT_BITS-1:0] r_held, n_held;
    t_event                     r_ev [3];
    t_event                     n_ev [3];
    logic [1:0]                 r_num, n_num, r_pos;

    logic [HOLD_COUNT_BITS-1:0] held_base;
    logic [HOLD_COUNT_BITS:0]   held_sum;
    logic                       hold_done;
    logic                       take;

    assign o_pop = (r_num == 2'd0) && !i_empty;
    assign take  = o_event.valid && o_event.ready;
    assign hold_done = CMP_W'(r_held) >= CMP_W'(i_cfg.min_hold);

    always_comb begin
        n_sounding = r_sounding;
        n_note     = r_note;
        n_held     = r_held;
        n_num      = 2'd0;
        held_base  = r_held;
        for (int k = 0; k < 3; k++) begin
            n_ev[k] = '0;
        end
        if (i_rec.pitch_ok) begin
            if (!r_sounding) begin
                n_ev[0]    = '{EV_NOTE_ON, i_rec.target, i_rec.velocity, '0};
                n_num      = 2'd1;
                n_sounding = 1'b1;
                n_note     = i_rec.target;
                held_base  = '0;
            end else if (r_note != i_rec.target && hold_done) begin
                n_ev[0]   = '{EV_NOTE_OFF, r_note, '0, '0};
                n_ev[1]   = '{EV_NOTE_ON, i_rec.target, i_rec.velocity, '0};
                n_num     = 2'd2;
                n_note    = i_rec.target;
                held_base = '0;
            end
            held_sum = (HOLD_COUNT_BITS+1)'(held_base) + (HOLD_COUNT_BITS+1)'(i_rec.len);
            n_held   = held_sum[HOLD_COUNT_BITS] ? HOLD_MAX : held_sum[HOLD_COUNT_BITS-1:0];
            n_ev[n_num] = '{EV_BEND, '0, '0, i_rec.bend};
            n_num       = n_num + 2'd1;
        end else begin
            held_sum = '0;
            if (r_sounding) begin
                n_ev[0]    = '{EV_NOTE_OFF, r_note, '0, '0};
                n_num      = 2'd1;
                n_sounding = 1'b0;
                n_note     = '0;
                n_held     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sounding <= 1'b0;
            r_note     <= '0;
            r_held     <= '0;
            r_num      <= 2'd0;
            r_pos      <= 2'd0;
        end else if (o_pop) begin
            r_sounding <= n_sounding;
            r_note     <= n_note;
            r_held     <= n_held;
            r_num      <= n_num;
            r_pos      <= 2'd0;
        end else if (take) begin
            if (r_pos + 2'd1 == r_num) begin
                r_num <= 2'd0;
                r_pos <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ev <= n_ev;
        end
    end

    assign o_event.valid         = (r_num != 2'd0);
    assign o_event.event_kind    = r_ev[r_pos].kind;
    assign o_event.channel       = i_cfg.channel;
    assign o_event.note_number   = r_ev[r_pos].note;
    assign o_event.note_velocity = r_ev[r_pos].velocity;
    assign o_event.bend_value    = r_ev[r_pos].bend;
    assign o_event.last_event    = (r_pos + 2'd1 == r_num);
endmodule

[rtl/core/pitch_to_midi_note_tracker_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// pitch_to_midi_note_tracker_core
// Pitch to MIDI note tracker: log2 note value, hold hysteresis, note/bend events.
// ============================================================================
//  channel   dir  handshake        payload
//  i_pitch   in   valid/ready      corrected_hz, confidence, block_samples
//  o_event   out  valid/ready      event_kind, channel, note_number,
//                                  note_velocity, bend_value, last_event
//  i_cfg_*   in   i_cfg_we only    i_cfg_idx, i_cfg_data
//
//  Front: a valid-pitch block steps through LZ, NORM, MUL, MIDI, TGT, BEND and
//  PUSH (log2 pipeline steps); an invalid pitch goes straight to PUSH and a
//  suppressed block is dropped. Back takes a record, then its events in order.
//  A two-entry record queue lets front and back stall independently.
//  Synchronous active-low reset; no clearing pass.
// ============================================================================
module pitch_to_midi_note_tracker_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ptm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ptm_pitch_if.sink                        i_pitch,
    ptm_event_if.source                      o_event
);
    import ptm_pkg::*;

    t_cfg r_cfg;
    t_rec w_push_rec, w_pop_rec;
    logic w_push, w_full, w_pop, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bypass     <= 1'b0;
            r_cfg.out_en     <= 1'b0;
            r_cfg.channel    <= '0;
            r_cfg.min_hold   <= MIN_HOLD_RST;
            r_cfg.conf_floor <= CONF_FLOOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BYPASS:     r_cfg.bypass     <= i_cfg_data[0];
                CFG_OUT_EN:     r_cfg.out_en     <= i_cfg_data[0];
                CFG_CHANNEL:    r_cfg.channel    <= i_cfg_data[CHAN_W-1:0];
                CFG_MIN_HOLD:   r_cfg.min_hold   <= i_cfg_data[HOLD_W-1:0];
                CFG_CONF_FLOOR: r_cfg.conf_floor <= i_cfg_data[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    ptm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pitch (i_pitch),
        .o_push  (w_push),
        .o_rec   (w_push_rec),
        .i_full  (w_full)
    );

    ptm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_rec),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_rec),
        .o_empty (w_empty)
    );

    ptm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_rec   (w_pop_rec),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_event (o_event)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("record queue overflow");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pitch.valid && i_pitch.ready && i_pitch.block_samples != '0 &&
         r_cfg.out_en && !r_cfg.bypass) |=> !i_pitch.ready)
        else $error("front took a second block while busy");

    a_bend_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && o_event.event_kind == EV_BEND) |->
            (o_event.note_number == '0 && o_event.note_velocity == '0 &&
             o_event.last_event))
        else $error("bend event with note fields or not last");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !o_event.valid)
        else $error("record taken while events pending");
endmodule

[test/ptm_event_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// ptm_event_checker
// Watches the pitch, event and register ports of the note tracker. It keeps
// its own copy of the note state and settings and predicts the MIDI events of
// each accepted block. Every event transfer is compared field by field with
// the oldest predicted event.
// ============================================================================
module ptm_event_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ptm_pitch_if                           pitch_mon,
    ptm_event_if                           event_mon,
    input  logic                           i_end_check,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_blocks_seen,
    output int                             o_events_seen
);
    import ptm_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] channel;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic [BEND_W-1:0] bend;
        logic              last;
    } t_midi_event;

    t_midi_event midi_events_due[$];

    longint unsigned log2_tab[LOG_TAB_N+1];
    longint          log2_a4;

    logic                       cfg_bypass;
    logic                       cfg_out_en;
    logic [CHAN_W-1:0]          cfg_channel;
    logic [HOLD_W-1:0]          cfg_min_hold;
    logic [CONF_W-1:0]          cfg_floor;

    logic                       note_on;
    logic [NOTE_W-1:0]          cur_note;
    logic [HOLD_COUNT_BITS-1:0] hold_count;

    // log2 of x in Q2.30, 1 <= x < 2, as Q16 by repeated squaring
    function automatic logic [15:0] mant_log2(input longint unsigned x_in);
        longint unsigned x;
        logic [15:0]     v;
        int              k;
        x = x_in;
        v = '0;
        for (k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            v = v << 1;
            if (x >= 64'h8000_0000) begin
                v[0] = 1'b1;
                x    = x >> 1;
            end
        end
        return v;
    endfunction

    // log2 of a Q13.10 pitch in Q16: leading one plus interpolated table
    function automatic longint pitch_log2(input logic [HZ_W-1:0] hz);
        int              p;
        int              k;
        longint unsigned m, f, prod, idx, rem, lo, hi;
        p = 0;
        for (k = 0; k < HZ_W; k++) begin
            if (hz[k]) p = k;
        end
        m    = 64'(hz) << (31 - p);
        f    = m - 64'h8000_0000;
        prod = f * 64'(LOG_TAB_N);
        idx  = prod >> 31;
        if (idx > 64'(LOG_TAB_N - 1)) idx = 64'(LOG_TAB_N - 1);
        rem  = prod - (idx << 31);
        lo   = log2_tab[idx];
        hi   = log2_tab[idx + 1];
        return longint'(p) * 65536 + longint'(lo + (((hi - lo) * rem) >> 31));
    endfunction

    function automatic t_midi_event make_event(input logic [KIND_W-1:0] kind,
                                               input logic [NOTE_W-1:0] note,
                                               input logic [VEL_W-1:0] vel,
                                               input logic [BEND_W-1:0] bend);
        t_midi_event ev;
        ev.kind     = kind;
        ev.channel  = cfg_channel;
        ev.note     = note;
        ev.velocity = vel;
        ev.bend     = bend;
        ev.last     = 1'b0;
        return ev;
    endfunction

    task automatic track_block(input logic [HZ_W-1:0] hz, input logic [CONF_W-1:0] conf,
                               input logic [LEN_W-1:0] len);
        longint                   midi, target, d, q, bend;
        longint unsigned          mag;
        int                       vel;
        logic [HOLD_COUNT_BITS:0] hold_sum;
        t_midi_event              evs[$];
        if (cfg_bypass || !cfg_out_en || len == 0) return;
        if (hz != 0 && conf > cfg_floor) begin
            midi = 69 * 65536 + 12 * (pitch_log2(hz) - log2_a4);
            if (midi >= 0) target = (midi + 32768) / 65536;
            else target = -((-midi + 32768) / 65536);
            if (target < 0) target = 0;
            if (target > 127) target = 127;

            vel = (int'(conf) * 100 + 27 * 65536) >>> 16;
            if (vel < 1) vel = 1;
            if (vel > 127) vel = 127;

            if (!note_on) begin
                evs = {evs, make_event(EV_NOTE_ON, target[NOTE_W-1:0], vel[VEL_W-1:0], '0)};
                note_on    = 1'b1;
                cur_note   = target[NOTE_W-1:0];
                hold_count = '0;
            end else if (cur_note != target[NOTE_W-1:0] && hold_count >= cfg_min_hold) begin
                evs = {evs, make_event(EV_NOTE_OFF, cur_note, '0, '0)};
                evs = {evs, make_event(EV_NOTE_ON, target[NOTE_W-1:0], vel[VEL_W-1:0], '0)};
                cur_note   = target[NOTE_W-1:0];
                hold_count = '0;
            end

            // hold count saturates
            hold_sum   = {1'b0, hold_count} + len;
            hold_count = hold_sum[HOLD_COUNT_BITS] ? '1 : hold_sum[HOLD_COUNT_BITS-1:0];

            d    = midi - target * 65536;
            mag  = (d < 0) ? -d : d;
            q    = longint'((mag * 8191) / 131072);
            if (q > 16384) q = 16384;
            bend = (d < 0) ? 8192 - q : 8192 + q;
            if (bend < 0) bend = 0;
            if (bend > 16383) bend = 16383;
            evs = {evs, make_event(EV_BEND, '0, '0, bend[BEND_W-1:0])};
        end else if (note_on) begin
            evs = {evs, make_event(EV_NOTE_OFF, cur_note, '0, '0)};
            note_on    = 1'b0;
            cur_note   = '0;
            hold_count = '0;
        end
        if (evs.size() > 0) begin
            evs[evs.size()-1].last = 1'b1;
            midi_events_due = {midi_events_due, evs};
        end
    endtask

    task automatic report(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("event %0d %s: got %0d, expected %0d",
                             o_events_seen, name, got, want));
    endtask

    initial begin
        for (int i = 0; i < LOG_TAB_N; i++)
            log2_tab[i] = 64'(mant_log2(((64'(LOG_TAB_N) + 64'(i)) << 30) /
                                        64'(LOG_TAB_N)));
        log2_tab[LOG_TAB_N] = 64'd65536;
        log2_a4 = pitch_log2(23'(440 * 1024));
    end

    always @(posedge i_clk) begin
        t_midi_event want;
        if (!i_rst_n) begin
            cfg_bypass    = 1'b0;
            cfg_out_en    = 1'b0;
            cfg_channel   = '0;
            cfg_min_hold  = 24'd2205;
            cfg_floor     = 16'd19660;
            note_on       = 1'b0;
            cur_note      = '0;
            hold_count    = '0;
            o_fail_count  = 0;
            o_blocks_seen = 0;
            o_events_seen = 0;
            midi_events_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BYPASS:     cfg_bypass   = i_cfg_data[0];
                    CFG_OUT_EN:     cfg_out_en   = i_cfg_data[0];
                    CFG_CHANNEL:    cfg_channel  = i_cfg_data[CHAN_W-1:0];
                    CFG_MIN_HOLD:   cfg_min_hold = i_cfg_data[HOLD_W-1:0];
                    CFG_CONF_FLOOR: cfg_floor    = i_cfg_data[CONF_W-1:0];
                    default: ;
                endcase
            end
            if (pitch_mon.valid && pitch_mon.ready) begin
                track_block(pitch_mon.corrected_hz, pitch_mon.confidence,
                            pitch_mon.block_samples);
                o_blocks_seen++;
            end
            if (event_mon.valid && event_mon.ready) begin
                if (midi_events_due.size() == 0) begin
                    report($sformatf("event %0d arrived with none due, kind %0d note %0d",
                                     o_events_seen, event_mon.event_kind,
                                     event_mon.note_number));
                end else begin
                    want = midi_events_due.pop_front();
                    check_field("kind", int'(event_mon.event_kind), int'(want.kind));
                    check_field("channel", int'(event_mon.channel), int'(want.channel));
                    check_field("note", int'(event_mon.note_number), int'(want.note));
                    check_field("velocity", int'(event_mon.note_velocity),
                                int'(want.velocity));
                    check_field("bend", int'(event_mon.bend_value), int'(want.bend));
                    check_field("last", int'(event_mon.last_event), int'(want.last));
                end
                o_events_seen++;
            end
            if (i_end_check && midi_events_due.size() != 0)
                report($sformatf("%0d events never arrived", midi_events_due.size()));
        end
        o_pending <= midi_events_due.size();
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives audio blocks into the note tracker under a series of register
// settings: directed edge cases first, then melodic sequences with noise,
// a long output stall and a run of long blocks against a large minimum
// hold. The checker beside the block predicts and compares every MIDI event.
// ============================================================================
module testbench;
    import ptm_pkg::*;

    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLDOFF_CYCLES = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  end_check;

    int fail_count, pending, blocks_seen, events_seen;
    int settings_used = 0;
    bit idle_en = 1'b1;
    int holdoff_reqs = 0;
    int mel_note = 60;
    int mel_left = 0;
    logic [CONF_W-1:0] cur_floor = 16'd19660;

    ptm_pitch_if pitch_ch ();
    ptm_event_if event_ch ();

    pitch_to_midi_note_tracker_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pitch    (pitch_ch),
        .o_event    (event_ch)
    );

    ptm_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .pitch_mon     (pitch_ch),
        .event_mon     (event_ch),
        .i_end_check   (end_check),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_blocks_seen (blocks_seen),
        .o_events_seen (events_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    // event receiver: random stalls plus a long hold-off on request
    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        event_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != holdoff_reqs) begin
                served    = holdoff_reqs;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0) begin
                event_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                event_ch.ready <= !(idle_en && $urandom_range(99, 0) < 8);
            end
        end
    end

    function automatic logic [HZ_W-1:0] note_to_hz(input real note_val);
        return HZ_W'($rtoi(440.0 * 2.0 ** ((note_val - 69.0) / 12.0) * 1024.0));
    endfunction

    task automatic send_block(input logic [HZ_W-1:0] hz, input logic [CONF_W-1:0] conf,
                              input logic [LEN_W-1:0] len);
        pitch_ch.valid         <= 1'b1;
        pitch_ch.corrected_hz  <= hz;
        pitch_ch.confidence    <= conf;
        pitch_ch.block_samples <= len;
        do @(posedge i_clk); while (!pitch_ch.ready);
        if (idle_en && $urandom_range(99, 0) < 8) begin
            pitch_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // stop offering, wait for every due event, then let the pipeline settle
    task automatic settle();
        pitch_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input bit bypass, input bit out_en, input logic [3:0] chan,
                                input logic [23:0] min_hold, input logic [15:0] floor_q16);
        logic [CFG_IDX_W-1:0]  codes[5];
        logic [CFG_DATA_W-1:0] vals[5];
        codes = '{CFG_BYPASS, CFG_OUT_EN, CFG_CHANNEL, CFG_MIN_HOLD, CFG_CONF_FLOOR};
        vals  = '{24'(bypass), 24'(out_en), 24'(chan), min_hold, 24'(floor_q16)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= codes[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cur_floor  = floor_q16;
        settings_used++;
    endtask

    // mostly held notes with detune, plus silence, raw noise and empty blocks
    task automatic next_random_block(output logic [HZ_W-1:0] hz, output logic [CONF_W-1:0] conf,
                                     output logic [LEN_W-1:0] len);
        int  r, lr;
        real detune;
        r  = $urandom_range(99, 0);
        lr = $urandom_range(99, 0);
        if (lr < 90) len = LEN_W'($urandom_range(1024, 32));
        else if (lr < 95) len = '1;
        else len = LEN_W'($urandom);
        if (r < 80) begin
            if (mel_left == 0) begin
                mel_note = $urandom_range(108, 21);
                mel_left = $urandom_range(8, 1);
            end
            mel_left--;
            detune = ($itor($urandom_range(900, 0)) - 450.0) / 1000.0;
            hz     = note_to_hz(mel_note + detune);
            conf   = (cur_floor == '1) ? '1 : CONF_W'($urandom_range(65535, cur_floor + 1));
        end else if (r < 88) begin
            hz   = ($urandom_range(1, 0) != 0) ? '0 : note_to_hz(mel_note);
            conf = CONF_W'($urandom_range(cur_floor, 0));
        end else if (r < 95) begin
            hz   = HZ_W'($urandom);
            conf = CONF_W'($urandom);
            len  = LEN_W'($urandom);
        end else begin
            hz   = HZ_W'($urandom);
            conf = CONF_W'($urandom);
            len  = '0;
        end
    endtask

    task automatic run_random(input int count);
        logic [HZ_W-1:0]   hz;
        logic [CONF_W-1:0] conf;
        logic [LEN_W-1:0]  len;
        repeat (count) begin
            next_random_block(hz, conf, len);
            send_block(hz, conf, len);
        end
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= CFG_BYPASS;
        i_cfg_data             <= '0;
        end_check              <= 1'b0;
        pitch_ch.valid         <= 1'b0;
        pitch_ch.corrected_hz  <= '0;
        pitch_ch.confidence    <= '0;
        pitch_ch.block_samples <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // output disabled out of reset
        send_block(note_to_hz(69.0), '1, 16'd256);
        send_block(note_to_hz(60.0), '1, 16'd256);
        settle();

        // directed
        write_config(1'b0, 1'b1, 4'd3, 24'd2205, 16'd19660);
        send_block(23'd450560, '1, 16'd256);          // A4 on, centered bend
        send_block(23'd450560, 16'd30000, 16'd1000);  // same note, bend only
        send_block(note_to_hz(72.0), 16'd40000, 16'd500); // hold too short
        send_block(23'd450560, '1, '1);
        send_block(note_to_hz(72.0), 16'd40000, 16'd500); // off, on, bend
        send_block('1, '1, '1);                       // top of pitch range
        send_block(23'd1, '1, 16'd1);                 // bottom of pitch range
        send_block('0, '1, 16'd100);                  // no pitch: note off
        send_block('0, '1, 16'd100);                  // nothing sounding
        send_block(23'd450560, 16'd19660, 16'd100);   // confidence at floor
        send_block(23'd450560, 16'd19661, 16'd100);   // just above floor
        send_block(23'd450560, '0, 16'd100);
        send_block(23'd450560, '1, '0);               // empty block
        send_block(23'd450560, '1, '1);
        send_block(note_to_hz(69.5), '1, '1);         // half-semitone rounding
        send_block(note_to_hz(69.49), '1, '1);
        send_block(note_to_hz(69.51), '1, '1);
        send_block(23'd1024, 16'd50000, 16'd300);
        send_block(note_to_hz(0.0), 16'd50000, '1);
        send_block('0, '0, '1);
        settle();

        // bypass and disable with and without a sounding note
        write_config(1'b1, 1'b1, 4'd5, 24'd0, 16'd0);
        send_block(note_to_hz(64.0), '1, 16'd256);
        send_block('0, '1, 16'd256);
        settle();
        write_config(1'b0, 1'b1, 4'd15, 24'd0, 16'd0);
        send_block(note_to_hz(64.0), 16'd1, 16'd256);
        send_block(note_to_hz(65.0), '1, 16'd256);
        settle();
        write_config(1'b0, 1'b0, 4'd15, 24'd0, 16'd0);
        send_block('0, '1, 16'd256);
        send_block(note_to_hz(40.0), '1, 16'd256);
        settle();
        write_config(1'b1, 1'b1, 4'd15, 24'd0, 16'd0);
        send_block(note_to_hz(41.0), '1, 16'd256);
        settle();
        write_config(1'b0, 1'b1, 4'd15, 24'd0, 16'd0);
        send_block(note_to_hz(65.0), 16'd0, 16'd256);
        settle();

        // random sequences
        write_config(1'b0, 1'b1, 4'($urandom), 24'd2205, 16'd19660);
        run_random(30);
        settle();
        write_config(1'b0, 1'b1, 4'd0, 24'($urandom_range(3000, 100)),
                     16'($urandom_range(50000, 5000)));
        run_random(25);
        settle();
        write_config(1'b1, 1'b1, 4'd0, 24'd500, 16'd10000);
        run_random(8);
        settle();
        write_config(1'b0, 1'b1, 4'($urandom), 24'd500, 16'd10000);
        run_random(25);
        settle();
        idle_en = 1'b0;
        write_config(1'b0, 1'b1, 4'd15, 24'd0, 16'd0);
        run_random(30);
        settle();

        // long output stall while blocks keep coming
        write_config(1'b0, 1'b1, 4'd7, 24'd0, 16'd0);
        holdoff_reqs++;
        for (int i = 0; i < 30; i++)
            send_block(note_to_hz(48.0 + (i % 5) * 3.0), '1, 16'd128);
        settle();
        idle_en = 1'b1;

        write_config(1'b0, 1'b1, 4'($urandom), '1, '1);
        run_random(10);
        settle();

        // long blocks against a large minimum hold, then a note change
        write_config(1'b0, 1'b1, 4'd9, 24'd600000, 16'd0);
        for (int i = 0; i < 15; i++) begin
            if (i % 4 == 3) send_block(note_to_hz(64.0), '1, '1);
            else send_block(note_to_hz(60.0), 16'($urandom_range(65535, 1)), '1);
        end
        settle();

        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        repeat (2) @(posedge i_clk);

        $display("Ran %0d pitch blocks and checked %0d MIDI events under %0d register settings,",
                 blocks_seen, events_seen, settings_used);
        $display("with bypass, disabled output, a long output stall and long held notes.");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ptm_pkg.sv
rtl/core/ptm_pitch_if.sv
rtl/core/ptm_event_if.sv
rtl/core/ptm_queue.sv
rtl/core/ptm_front.sv
rtl/core/ptm_back.sv
rtl/core/pitch_to_midi_note_tracker_core.sv
test/ptm_event_checker.sv
test/testbench.sv
